@@ src/base64_stream_codec_top_assert.svh @@
// Assertion macros shared by the base64 stream codec modules.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef BASE64_STREAM_CODEC_TOP_ASSERT_SVH
`define BASE64_STREAM_CODEC_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define B64SC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define B64SC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define B64SC_ASSERT_IMPL(name, ante, cons, msg)
`define B64SC_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

@@ src/b64sc_pkg.sv @@
// Package for the base64 stream codec: payload structs, command format,
// result kinds, register indexes and the alphabet mapping functions.
package b64sc_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int ERR_OFF_W   = 32;
  localparam int CMD_DEPTH   = 4;
  localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANT   = 1'd1;

  // Result kinds
  localparam logic [2:0] KIND_DATA     = 3'd0;
  localparam logic [2:0] KIND_END_OK   = 3'd1;
  localparam logic [2:0] KIND_BAD_CHAR = 3'd2;
  localparam logic [2:0] KIND_BAD_LEN  = 3'd3;
  localparam logic [2:0] KIND_STRAY    = 3'd4;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic [2:0]           kind;
    logic [ERR_OFF_W-1:0] error_offset;
    logic                 end_mark;
  } out_item_t;

  // Work for the back end: data bytes first, then an optional status
  typedef struct packed {
    logic [3:0][7:0]      data;
    logic [2:0]           n_data;
    logic                 has_status;
    logic [2:0]           kind;
    logic [ERR_OFF_W-1:0] err_off;
  } cmd_t;

  // Map a 6-bit digit to its character
  function automatic logic [7:0] enc_char(logic [5:0] v, logic url);
    logic [7:0] c;
    if (v inside {[6'd0:6'd25]}) begin
      c = 8'h41 + {2'b00, v};
    end else if (v inside {[6'd26:6'd51]}) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v inside {[6'd52:6'd61]}) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = url ? 8'h2D : 8'h2B;
    end else begin
      c = url ? 8'h5F : 8'h2F;
    end
    return c;
  endfunction

  // Map a character to {valid, digit}
  function automatic logic [6:0] dec_char(logic [7:0] c, logic url);
    logic [7:0] t;
    logic [6:0] r;
    t = 8'h00;
    r = 7'h00;
    if (c inside {[8'h41:8'h5A]}) begin
      t = c - 8'h41;
      r = {1'b1, t[5:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      t = c - 8'h61 + 8'd26;
      r = {1'b1, t[5:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30 + 8'd52;
      r = {1'b1, t[5:0]};
    end else if ((url && c == 8'h2D) || (!url && c == 8'h2B)) begin
      r = {1'b1, 6'd62};
    end else if ((url && c == 8'h5F) || (!url && c == 8'h2F)) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

@@ src/b64sc_front.sv @@
// Front end of the base64 stream codec: accepts items, keeps the stream
// state and turns each item into at most one command. Depends on b64sc_pkg.
module b64sc_front import b64sc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     direction_i,
  input  logic     variant_i,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  input  logic     fifo_full_i,
  output logic     in_stall_o,
  output logic     push_o,
  output cmd_t     cmd_o
);

  logic [1:0]             phase_q, phase_d;
  logic [23:0]            acc_q, acc_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic                   pad_act_q, pad_act_d;
  logic [OFFSET_BITS-1:0] pad_start_q, pad_start_d;
  logic                   err_q, err_d;
  logic [OFFSET_BITS-1:0] err_off_q, err_off_d;
  logic                   accept;
  logic [6:0]             dec;
  logic [OFFSET_BITS-1:0] len_n;
  cmd_t                   cmd;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;
  assign dec        = dec_char(in_item_i.data_byte, variant_i);

  // Work out the next stream state and the command for this item
  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    pad_act_d   = pad_act_q;
    pad_start_d = pad_start_q;
    err_d       = err_q;
    err_off_d   = err_off_q;
    len_n       = '0;
    cmd         = '0;
    cmd.kind    = KIND_END_OK;

    if (!direction_i) begin
      // Encode: pack bytes into a 24-bit group
      if (in_item_i.has_data) begin
        if (phase_d == 2'd3) begin
          phase_d = 2'd0;
          acc_d   = '0;
        end
        case (phase_d)
          2'd0:    acc_d[23:16] = acc_d[23:16] | in_item_i.data_byte;
          2'd1:    acc_d[15:8]  = acc_d[15:8]  | in_item_i.data_byte;
          default: acc_d[7:0]   = acc_d[7:0]   | in_item_i.data_byte;
        endcase
        phase_d = phase_d + 2'd1;
        if (phase_d == 2'd3) begin
          cmd.data[0] = enc_char(acc_d[23:18], variant_i);
          cmd.data[1] = enc_char(acc_d[17:12], variant_i);
          cmd.data[2] = enc_char(acc_d[11:6], variant_i);
          cmd.data[3] = enc_char(acc_d[5:0], variant_i);
          cmd.n_data  = 3'd4;
          phase_d     = 2'd0;
          acc_d       = '0;
        end
        pos_d = pos_d + 1'b1;
      end
      // Flush a partial group, pad in the standard variant
      if (in_item_i.last) begin
        if (phase_d == 2'd1 || phase_d == 2'd2) begin
          cmd.data[0] = enc_char(acc_d[23:18], variant_i);
          cmd.data[1] = enc_char(acc_d[17:12], variant_i);
          cmd.data[2] = (phase_d == 2'd2) ? enc_char(acc_d[11:6], variant_i) : PAD_CHAR;
          cmd.data[3] = PAD_CHAR;
          if (!variant_i) begin
            cmd.n_data = 3'd4;
          end else begin
            cmd.n_data = (phase_d == 2'd2) ? 3'd3 : 3'd2;
          end
        end
        cmd.has_status = 1'b1;
        cmd.kind       = KIND_END_OK;
      end
    end else begin
      // Decode: track the pad run, gather digits
      if (in_item_i.has_data) begin
        if (in_item_i.data_byte == PAD_CHAR) begin
          if (!pad_act_d) begin
            pad_act_d   = 1'b1;
            pad_start_d = pos_d;
          end
        end else begin
          if (pad_act_d) begin
            if (!err_d) begin
              err_d     = 1'b1;
              err_off_d = pad_start_d;
            end
            pad_act_d = 1'b0;
          end
          if (!dec[6]) begin
            if (!err_d) begin
              err_d     = 1'b1;
              err_off_d = pos_d;
            end
          end else begin
            acc_d = {acc_d[17:0], dec[5:0]};
            if (phase_d == 2'd3) begin
              if (!err_d) begin
                cmd.data[0] = acc_d[23:16];
                cmd.data[1] = acc_d[15:8];
                cmd.data[2] = acc_d[7:0];
                cmd.n_data  = 3'd3;
              end
              phase_d = 2'd0;
              acc_d   = '0;
            end else begin
              phase_d = phase_d + 2'd1;
            end
          end
        end
        pos_d = pos_d + 1'b1;
      end
      // Check length and errors at end of stream, then flush the tail
      if (in_item_i.last) begin
        len_n          = pad_act_d ? pad_start_d : pos_d;
        cmd.has_status = 1'b1;
        if (!variant_i && pos_d[1:0] != 2'd0) begin
          cmd.kind = KIND_BAD_LEN;
        end else if (len_n[1:0] == 2'd1) begin
          cmd.kind = KIND_STRAY;
        end else if (err_d) begin
          cmd.kind    = KIND_BAD_CHAR;
          cmd.err_off = ERR_OFF_W'(err_off_d);
        end else begin
          cmd.kind = KIND_END_OK;
          if (phase_d == 2'd2) begin
            cmd.data[0] = acc_d[11:4];
            cmd.n_data  = 3'd1;
          end else if (phase_d == 2'd3) begin
            cmd.data[0] = acc_d[17:10];
            cmd.data[1] = acc_d[9:2];
            cmd.n_data  = 3'd2;
          end
        end
      end
    end

    // Drop all stream state once the stream closes
    if (in_item_i.last) begin
      phase_d     = '0;
      acc_d       = '0;
      pos_d       = '0;
      pad_act_d   = 1'b0;
      pad_start_d = '0;
      err_d       = 1'b0;
      err_off_d   = '0;
    end
  end

  assign push_o = accept && (cmd.n_data != 3'd0 || cmd.has_status);
  assign cmd_o  = cmd;

  // Advance stream state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      acc_q       <= '0;
      pos_q       <= '0;
      pad_act_q   <= 1'b0;
      pad_start_q <= '0;
      err_q       <= 1'b0;
      err_off_q   <= '0;
    end else if (accept) begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      pad_act_q   <= pad_act_d;
      pad_start_q <= pad_start_d;
      err_q       <= err_d;
      err_off_q   <= err_off_d;
    end
  end

endmodule

@@ src/b64sc_cmd_fifo.sv @@
// Command queue between the codec front and back ends.
// Depends on b64sc_pkg and the assertion macro header.
`include "base64_stream_codec_top_assert.svh"

module b64sc_cmd_fifo import b64sc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic vld_o,
  output cmd_t head_o
);

  cmd_t                 entries_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_PTR_W:0]   cnt_q;
  logic                 do_pop;

  assign full_o = (cnt_q == (CMD_PTR_W+1)'(CMD_DEPTH));
  assign vld_o  = (cnt_q != '0);
  assign head_o = entries_q[rd_ptr_q];
  assign do_pop = pop_i && vld_o;

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `B64SC_ASSERT_IMPL(a_no_push_full, push_i, !full_o, "command pushed into full queue")
  `B64SC_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= (CMD_PTR_W+1)'(CMD_DEPTH), "queue overrun")

endmodule

@@ src/b64sc_back.sv @@
// Back end of the base64 stream codec: expands each command into result items,
// one per cycle unless the output stalls, into an output register. Depends on b64sc_pkg.
`include "base64_stream_codec_top_assert.svh"

module b64sc_back import b64sc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_vld_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic [2:0] idx_q;
  logic       out_valid_q;
  out_item_t  out_q;
  logic [2:0] total;
  logic       advance;
  logic       at_end;
  out_item_t  res;

  assign total   = cmd_i.n_data + {2'b00, cmd_i.has_status};
  assign advance = cmd_vld_i && (!out_valid_q || !out_stall_i);
  assign at_end  = (idx_q == total - 3'd1);
  assign cmd_pop_o = advance && at_end;

  // Pick the data byte or the closing status for the current slot
  always_comb begin
    res = '0;
    if (idx_q < cmd_i.n_data) begin
      res.out_byte = cmd_i.data[idx_q[1:0]];
      res.kind     = KIND_DATA;
    end else begin
      res.kind         = cmd_i.kind;
      res.error_offset = cmd_i.err_off;
      res.end_mark     = 1'b1;
    end
  end

  // Load the output register and step through the command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        idx_q       <= at_end ? 3'd0 : idx_q + 3'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `B64SC_ASSERT_IMPL(a_idx_in_cmd, cmd_vld_i, idx_q < total, "slot index past command end")
  `B64SC_ASSERT_IMPL(a_end_is_status, out_valid_q,
                     out_q.end_mark == (out_q.kind != KIND_DATA), "end mark mismatch")
  `B64SC_ASSERT_IMPL(a_data_no_off, out_valid_q && out_q.kind == KIND_DATA,
                     out_q.error_offset == '0, "offset on data result")

endmodule

@@ src/base64_stream_codec_top.sv @@
// Base64 stream codec: an accepted item's first result is registered in the command
// queue, then in the back end's output register. The back end emits one result per
// cycle while output is not stalled; encode gives four characters per three bytes.
// A four-entry command queue lets input run ahead while output is stalled.
// Reset clears stream state, the queue and the configuration (encode, standard).
// Depends on b64sc_pkg, b64sc_front, b64sc_cmd_fifo and b64sc_back.
module base64_stream_codec_top import b64sc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  logic direction_q;
  logic variant_q;
  logic fifo_full;
  logic push;
  cmd_t push_cmd;
  logic head_vld;
  cmd_t head_cmd;
  logic pop;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
      variant_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIRECTION: direction_q <= cfg_wdata_i;
        REG_VARIANT:   variant_q   <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  b64sc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .direction_i (direction_q),
    .variant_i   (variant_q),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .fifo_full_i (fifo_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  b64sc_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .vld_o       (head_vld),
    .head_o      (head_cmd)
  );

  b64sc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_vld_i   (head_vld),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ tb/tb_base64_stream_codec_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for base64_stream_codec_top: a directed stimulus table and then
// random encode/decode streams, checked against an in-bench codec model. Depends on b64sc_pkg.
module tb_base64_stream_codec_top;
  import b64sc_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 10;
  localparam int QUIET_CYCLES   = 8;
  localparam int MAX_PRINTS     = 40;
  localparam int TIMEOUT_CYCLES = 250_000;

  // One row of the directed table: a register setting or an item
  typedef struct {
    bit        cfg;
    bit        dec;
    bit        url;
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic                 cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_item_o;

  // Codec model state and register copies
  logic        cfg_decode;
  logic        cfg_url;
  logic [1:0]  grp_phase;
  logic [23:0] acc;
  logic [31:0] pos;
  logic        pad_active;
  logic [31:0] pad_start;
  logic        err_seen;
  logic [31:0] err_off;

  out_item_t step_q[$];
  out_item_t expected_q[$];
  stim_row_t dir_rows[$];
  stim_row_t typed_pending[$];

  int err_count = 0;
  int send_pct  = 0;
  int recv_pct  = 0;
  bit cur_dec   = 1'b0;
  bit cur_url   = 1'b0;

  base64_stream_codec_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Codec model
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] digit_char(logic [5:0] v, logic url);
    if (v < 6'd26) return 8'h41 + v;
    if (v < 6'd52) return 8'h61 + v - 8'd26;
    if (v < 6'd62) return 8'h30 + v - 8'd52;
    if (v == 6'd62) return url ? 8'h2D : 8'h2B;
    return url ? 8'h5F : 8'h2F;
  endfunction

  // Return the 6-bit digit of a character, or -1 outside the alphabet
  function automatic int char_digit(logic [7:0] c, logic url);
    if (c inside {[8'h41:8'h5A]}) return int'(c) - 'h41;
    if (c inside {[8'h61:8'h7A]}) return int'(c) - 'h61 + 26;
    if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30 + 52;
    if (c == (url ? 8'h2D : 8'h2B)) return 62;
    if (c == (url ? 8'h5F : 8'h2F)) return 63;
    return -1;
  endfunction

  function automatic void restart_stream();
    grp_phase  = '0;
    acc        = '0;
    pos        = '0;
    pad_active = 1'b0;
    pad_start  = '0;
    err_seen   = 1'b0;
    err_off    = '0;
  endfunction

  function automatic void emit_data(logic [7:0] b);
    step_q.push_back('{out_byte: b, kind: KIND_DATA, error_offset: '0, end_mark: 1'b0});
  endfunction

  function automatic void emit_status(logic [2:0] k, logic [31:0] off);
    step_q.push_back('{out_byte: 8'h00, kind: k, error_offset: off, end_mark: 1'b1});
  endfunction

  function automatic void flag_error(logic [31:0] at);
    if (!err_seen) begin
      err_seen = 1'b1;
      err_off  = at;
    end
  endfunction

  // Work out the results of one accepted item into step_q
  function automatic void codec_step(in_item_t it);
    int          d;
    logic [31:0] n;
    step_q.delete();
    if (!cfg_decode) begin
      if (it.has_data) begin
        // a phase of three left by a mid-stream switch counts as an empty group
        if (grp_phase == 2'd3) begin
          grp_phase = '0;
          acc       = '0;
        end
        acc       = acc | ({16'h0000, it.data_byte} << (16 - 8 * grp_phase));
        grp_phase = grp_phase + 2'd1;
        if (grp_phase == 2'd3) begin
          emit_data(digit_char(acc[23:18], cfg_url));
          emit_data(digit_char(acc[17:12], cfg_url));
          emit_data(digit_char(acc[11:6], cfg_url));
          emit_data(digit_char(acc[5:0], cfg_url));
          grp_phase = '0;
          acc       = '0;
        end
        pos = pos + 32'd1;
      end
      if (it.last) begin
        if (grp_phase == 2'd1 || grp_phase == 2'd2) begin
          emit_data(digit_char(acc[23:18], cfg_url));
          emit_data(digit_char(acc[17:12], cfg_url));
          if (grp_phase == 2'd2) emit_data(digit_char(acc[11:6], cfg_url));
          else if (!cfg_url) emit_data(PAD_CHAR);
          if (!cfg_url) emit_data(PAD_CHAR);
        end
        emit_status(KIND_END_OK, '0);
        restart_stream();
      end
    end else begin
      if (it.has_data) begin
        if (it.data_byte == PAD_CHAR) begin
          if (!pad_active) begin
            pad_active = 1'b1;
            pad_start  = pos;
          end
        end else begin
          // a non-pad character ends a pad run: the run was not trailing
          if (pad_active) begin
            flag_error(pad_start);
            pad_active = 1'b0;
          end
          d = char_digit(it.data_byte, cfg_url);
          if (d < 0) begin
            flag_error(pos);
          end else begin
            acc = {acc[17:0], d[5:0]};
            if (grp_phase == 2'd3) begin
              if (!err_seen) begin
                emit_data(acc[23:16]);
                emit_data(acc[15:8]);
                emit_data(acc[7:0]);
              end
              grp_phase = '0;
              acc       = '0;
            end else begin
              grp_phase = grp_phase + 2'd1;
            end
          end
        end
        pos = pos + 32'd1;
      end
      if (it.last) begin
        // length first, then a stray character, then the first alphabet error
        n = pad_active ? pad_start : pos;
        if (!cfg_url && pos[1:0] != 2'd0) begin
          emit_status(KIND_BAD_LEN, '0);
        end else if (n[1:0] == 2'd1) begin
          emit_status(KIND_STRAY, '0);
        end else if (err_seen) begin
          emit_status(KIND_BAD_CHAR, err_off);
        end else begin
          if (grp_phase == 2'd2) begin
            emit_data(acc[11:4]);
          end else if (grp_phase == 2'd3) begin
            emit_data(acc[17:10]);
            emit_data(acc[9:2]);
          end
          emit_status(KIND_END_OK, '0);
        end
        restart_stream();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    if (err_count < MAX_PRINTS) $display("ERROR @%0t: %s", $time, what);
    err_count++;
  endtask

  // Track register writes, predict accepted items, check accepted results
  always @(posedge clk_i) begin : scoreboard
    stim_row_t row;
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      cfg_decode = 1'b0;
      cfg_url    = 1'b0;
      restart_stream();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_DIRECTION) cfg_decode = cfg_wdata_i;
        else if (cfg_idx_i == REG_VARIANT) cfg_url = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_o) begin
        codec_step(in_item_i);
        // a table row with a typed result replaces the model's expectation
        if (typed_pending.size() != 0) begin
          row = typed_pending.pop_front();
          if (row.typed) begin
            step_q.delete();
            step_q.push_back(row.want);
          end
        end
        foreach (step_q[i]) expected_q.push_back(step_q[i]);
      end
      if (out_valid_o && !out_stall_i) begin
        got = out_item_o;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", got));
        end else begin
          want = expected_q.pop_front();
          if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
          if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
          if (got.error_offset !== want.error_offset)
            report_mismatch($sformatf("error_offset %0d, expected %0d",
                                      got.error_offset, want.error_offset));
          if (got.end_mark !== want.end_mark)
            report_mismatch($sformatf("end_mark %b, expected %b", got.end_mark, want.end_mark));
        end
      end
    end
  end

  // Stall the output side at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_pct);
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Idle at random, then hold the item until it is accepted
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers once the block has gone quiet
  task automatic write_cfg(bit dec, bit url);
    drain_results();
    repeat (QUIET_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DIRECTION;
    cfg_wdata_i <= dec;
    @(posedge clk_i);
    cfg_idx_i   <= REG_VARIANT;
    cfg_wdata_i <= url;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_dec = dec;
    cur_url = url;
  endtask

  function automatic void add_cfg(bit dec, bit url);
    stim_row_t r;
    r.cfg   = 1'b1;
    r.dec   = dec;
    r.url   = url;
    r.item  = '0;
    r.typed = 1'b0;
    r.want  = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_item(logic [7:0] b, bit has, bit last);
    stim_row_t r;
    r.cfg   = 1'b0;
    r.dec   = 1'b0;
    r.url   = 1'b0;
    r.item  = '{data_byte: b, has_data: has, last: last};
    r.typed = 1'b0;
    r.want  = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_status(logic [7:0] b, bit has, bit last, logic [2:0] k,
                                     logic [31:0] off);
    stim_row_t r;
    r.cfg   = 1'b0;
    r.dec   = 1'b0;
    r.url   = 1'b0;
    r.item  = '{data_byte: b, has_data: has, last: last};
    r.typed = 1'b1;
    r.want  = '{out_byte: 8'h00, kind: k, error_offset: off, end_mark: 1'b1};
    dir_rows.push_back(r);
  endfunction

  // Random streams: encode bytes, or decode mostly well-formed text with some broken
  task automatic run_random(int quota);
    int          sent;
    int          streams;
    int          len;
    int          r;
    int          p;
    int          k;
    bit          pad;
    bit          paused;
    logic [23:0] grp;
    logic [7:0]  raw[$];
    logic [7:0]  txt[$];
    in_item_t    seq[$];
    sent    = 0;
    streams = 0;
    paused  = 1'b0;
    while (sent < quota) begin
      if (streams == 0 || $urandom_range(3) == 0) write_cfg($urandom_range(1), $urandom_range(1));
      raw.delete();
      txt.delete();
      seq.delete();
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
      for (k = 0; k < len; k++) raw.push_back($urandom_range(255));
      if (!cur_dec) begin
        txt = raw;
      end else begin
        r = $urandom_range(99);
        if (r < 80) begin
          // encode the bytes into text, padded where the variant allows
          pad = !cur_url || $urandom_range(1);
          for (k = 0; k < len; k += 3) begin
            grp = {raw[k], (k + 1 < len) ? raw[k + 1] : 8'h00, (k + 2 < len) ? raw[k + 2] : 8'h00};
            txt.push_back(digit_char(grp[23:18], cur_url));
            txt.push_back(digit_char(grp[17:12], cur_url));
            if (k + 1 < len) txt.push_back(digit_char(grp[11:6], cur_url));
            else if (pad) txt.push_back(PAD_CHAR);
            if (k + 2 < len) txt.push_back(digit_char(grp[5:0], cur_url));
            else if (pad) txt.push_back(PAD_CHAR);
          end
          // break some of them with one edit
          if (r >= 60) begin
            p = $urandom_range(txt.size());
            case ($urandom_range(3))
              0: if (p < txt.size()) txt[p] = $urandom_range(255);
              1: txt.insert(p, PAD_CHAR);
              2: if (p < txt.size()) txt.delete(p);
              default: txt.push_back(digit_char($urandom_range(63), cur_url));
            endcase
          end
        end else begin
          // noise: pads, alphabet characters and raw bytes
          for (k = $urandom_range(1, 9); k > 0; k--) begin
            case ($urandom_range(3))
              0: txt.push_back(PAD_CHAR);
              1: txt.push_back(digit_char($urandom_range(63), cur_url));
              default: txt.push_back($urandom_range(255));
            endcase
          end
        end
      end
      foreach (txt[i]) begin
        if ($urandom_range(9) == 0)
          seq.push_back('{data_byte: $urandom_range(255), has_data: 1'b0, last: 1'b0});
        seq.push_back('{data_byte: txt[i], has_data: 1'b1, last: 1'b0});
      end
      if (seq.size() != 0 && $urandom_range(1)) seq[seq.size() - 1].last = 1'b1;
      else seq.push_back('{data_byte: $urandom_range(255), has_data: 1'b0, last: 1'b1});
      for (k = 0; k < seq.size(); k++) begin
        // hold off mid-stream until the block has caught up
        if (k == 1 && (!paused || $urandom_range(49) == 0)) begin
          drain_results();
          paused = 1'b1;
        end
        send_item(seq[k]);
        if (seq[k].has_data || seq[k].last) sent++;
      end
      streams++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_DIRECTION;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // encode, standard alphabet as left by reset
    add_status(8'h00, 1'b0, 1'b1, KIND_END_OK, '0);
    add_item(8'h5A, 1'b0, 1'b0);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hFF, 1'b1, 1'b0);
    add_item(8'hFB, 1'b1, 1'b1);
    add_item(8'hFF, 1'b1, 1'b1);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'h10, 1'b1, 1'b1);
    // encode, url alphabet: no padding
    add_cfg(1'b0, 1'b1);
    add_item(8'hFB, 1'b1, 1'b0);
    add_item(8'hFF, 1'b1, 1'b1);
    // decode, standard: padded group, short length, pad before a bad character
    add_cfg(1'b1, 1'b0);
    add_item("Q", 1'b1, 1'b0);
    add_item("Q", 1'b1, 1'b0);
    add_item(PAD_CHAR, 1'b1, 1'b0);
    add_item(PAD_CHAR, 1'b1, 1'b1);
    add_status("A", 1'b1, 1'b1, KIND_BAD_LEN, '0);
    add_item("A", 1'b1, 1'b0);
    add_item(PAD_CHAR, 1'b1, 1'b0);
    add_item("*", 1'b1, 1'b0);
    add_status(PAD_CHAR, 1'b1, 1'b1, KIND_BAD_CHAR, 32'd1);
    // decode, url: unpadded tail, stray character behind a pad
    add_cfg(1'b1, 1'b1);
    add_item("-", 1'b1, 1'b0);
    add_item("_", 1'b1, 1'b0);
    add_item("8", 1'b1, 1'b1);
    add_item("A", 1'b1, 1'b0);
    add_status(PAD_CHAR, 1'b1, 1'b1, KIND_STRAY, '0);

    send_pct = 20;
    recv_pct = 70;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg) begin
        write_cfg(dir_rows[i].dec, dir_rows[i].url);
      end else begin
        typed_pending.push_back(dir_rows[i]);
        send_item(dir_rows[i].item);
      end
    end

    run_random(140);
    send_pct = 70;
    recv_pct = 20;
    run_random(140);
    send_pct = 0;
    recv_pct = 0;
    run_random(140);

    drain_results();
    repeat (QUIET_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/b64sc_pkg.sv
src/b64sc_front.sv
src/b64sc_cmd_fifo.sv
src/b64sc_back.sv
src/base64_stream_codec_top.sv
tb/tb_base64_stream_codec_top.sv
